/* rtl/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// Command frame builder package
// Shared constants and types for the frame builder and its output sequencer.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam logic       CMD_BEGIN      = 1'b0;
  localparam logic       CMD_PAYLOAD    = 1'b1;
  localparam logic [7:0] START_MARK     = 8'h3E;
  localparam int unsigned OVERHEAD_BYTES = 5;
  localparam int unsigned MAX_RESULTS   = 5;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W         = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       too_large;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic    [CNT_W-1:0]       count;
  } burst_t;

endpackage

/* rtl/command_frame_builder.sv */
// ----------------------------------------------------------------------------
// Command frame builder
// Builds serial command frames with an additive checksum.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  command, cmd_id, payload_size,
//                                              payload_byte
//   out      output     out_valid_o/out_ready_i out_byte, frame_end,
//                                              too_large, run_end
//
// Each input transaction is decoded in the cycle it is accepted and its
// results (one to five; none for a dropped payload byte) are stored in the
// output sequencer, which delivers one per cycle while out_ready_i is high.
// The next transaction is accepted in the cycle the last result of the
// current one is taken.
// Reset closes any open frame and empties the sequencer.
// ----------------------------------------------------------------------------
module command_frame_builder #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  cmd_id_i,
  input  logic [15:0] payload_size_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        too_large_o,
  output logic        run_end_o
);

  logic            accept;
  logic            free;
  cfb_pkg::burst_t burst;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;

  cfb_frame_ctrl #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .command_i     (command_i),
    .cmd_id_i      (cmd_id_i),
    .payload_size_i(payload_size_i),
    .payload_byte_i(payload_byte_i),
    .burst_o       (burst)
  );

  cfb_out_seq u_out_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .frame_end_o(frame_end_o),
    .too_large_o(too_large_o),
    .run_end_o  (run_end_o)
  );

endmodule

/* rtl/cfb_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// Frame control
// Holds the open-frame state and turns one input transaction into the burst
// of frame bytes that it causes.
// ----------------------------------------------------------------------------
module cfb_frame_ctrl #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            command_i,
  input  logic [7:0]      cmd_id_i,
  input  logic [15:0]     payload_size_i,
  input  logic [7:0]      payload_byte_i,
  output cfb_pkg::burst_t burst_o
);

  localparam int unsigned SizeLimit = MAX_FRAME_BYTES - cfb_pkg::OVERHEAD_BYTES;

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] sum_next;
  logic [7:0] left_next;
  logic [7:0] check_byte;

  assign sum_next   = sum_q + payload_byte_i;
  assign left_next  = left_q - 8'd1;
  assign check_byte = payload_size_i[7:0] + cmd_id_i;

  always_comb begin
    open_d  = open_q;
    left_d  = left_q;
    sum_d   = sum_q;
    burst_o = '0;
    unique case (command_i)
      cfb_pkg::CMD_BEGIN: begin
        open_d = 1'b0;
        left_d = '0;
        sum_d  = '0;
        if (payload_size_i > 16'(SizeLimit)) begin
          burst_o.res[0].too_large = 1'b1;
          burst_o.count            = cfb_pkg::CNT_W'(1);
        end else begin
          burst_o.res[0].out_byte = cfb_pkg::START_MARK;
          burst_o.res[1].out_byte = cmd_id_i;
          burst_o.res[2].out_byte = payload_size_i[7:0];
          burst_o.res[3].out_byte = check_byte;
          if (payload_size_i == '0) begin
            burst_o.res[4].frame_end = 1'b1;
            burst_o.count            = cfb_pkg::CNT_W'(5);
          end else begin
            burst_o.count = cfb_pkg::CNT_W'(4);
            open_d        = 1'b1;
            left_d        = payload_size_i[7:0];
          end
        end
      end
      cfb_pkg::CMD_PAYLOAD: begin
        if (open_q) begin
          sum_d                   = sum_next;
          left_d                  = left_next;
          burst_o.res[0].out_byte = payload_byte_i;
          if (left_next != '0) begin
            burst_o.count = cfb_pkg::CNT_W'(1);
          end else begin
            burst_o.res[1].out_byte  = sum_next;
            burst_o.res[1].frame_end = 1'b1;
            burst_o.count            = cfb_pkg::CNT_W'(2);
            open_d                   = 1'b0;
            sum_d                    = '0;
          end
        end
      end
      default: begin
        burst_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      sum_q  <= '0;
    end else if (accept_i) begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
    end
  end

endmodule

/* rtl/cfb_out_seq.sv */
// ----------------------------------------------------------------------------
// Output sequencer
// Holds one burst of frame bytes and delivers it one result per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module cfb_out_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cfb_pkg::burst_t burst_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic            too_large_o,
  output logic            run_end_o
);

  cfb_pkg::result_t [cfb_pkg::MAX_RESULTS-1:0] res_q;
  logic [cfb_pkg::CNT_W-1:0] count_q;
  logic [cfb_pkg::IDX_W-1:0] idx_q;
  cfb_pkg::result_t          cur;
  logic                      last;
  logic                      pop;

  assign out_valid_o = (count_q != '0);
  assign cur         = res_q[idx_q];
  assign last        = (cfb_pkg::CNT_W'(idx_q) == count_q - cfb_pkg::CNT_W'(1));
  assign pop         = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (pop && last);

  assign out_byte_o  = cur.out_byte;
  assign frame_end_o = cur.frame_end;
  assign too_large_o = cur.too_large;
  assign run_end_o   = last;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= burst_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      count_q <= burst_i.count;
      idx_q   <= '0;
    end else if (pop) begin
      if (last) begin
        count_q <= '0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + cfb_pkg::IDX_W'(1);
      end
    end
  end

endmodule

/* verif/command_frame_builder_tb.sv */
// ----------------------------------------------------------------------------
// Command frame builder testbench
// Drives begin and payload transactions into the frame builder and predicts
// every frame byte it should emit: header, echoed payload, checksum, and the
// single flag byte of an oversize begin. Each output transaction is compared
// field by field with the oldest predicted byte. Directed tests cover empty,
// oversize, short, abandoned and stray-payload cases. Random traffic then
// runs under changing idle rates on both sides, with a long output hold-off
// and a full drain in between.
// ----------------------------------------------------------------------------
module command_frame_builder_tb;

  localparam int unsigned FRAME_LIMIT = 255;
  localparam int unsigned MAX_PAYLOAD = FRAME_LIMIT - cfb_pkg::OVERHEAD_BYTES;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       too_large;
    logic       run_end;
  } frame_byte_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic        command_i      = cfb_pkg::CMD_BEGIN;
  logic [7:0]  cmd_id_i       = 8'h00;
  logic [15:0] payload_size_i = 16'h0000;
  logic [7:0]  payload_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        too_large_o;
  logic        run_end_o;

  frame_byte_t expected_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;
  int unsigned framed_items   = 0;

  logic       frame_open = 1'b0;
  logic [7:0] bytes_left = 8'h00;
  logic [7:0] body_sum   = 8'h00;

  command_frame_builder #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .cmd_id_i      (cmd_id_i),
    .payload_size_i(payload_size_i),
    .payload_byte_i(payload_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .frame_end_o   (frame_end_o),
    .too_large_o   (too_large_o),
    .run_end_o     (run_end_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void push_frame_byte(logic [7:0] b, logic fe, logic tl, logic re);
    frame_byte_t fb;
    fb.out_byte  = b;
    fb.frame_end = fe;
    fb.too_large = tl;
    fb.run_end   = re;
    expected_bytes.push_back(fb);
  endfunction

  function automatic int unsigned predict_frame_bytes(logic cmd, logic [7:0] id,
                                                      logic [15:0] size, logic [7:0] data);
    logic [7:0] header_sum;
    int unsigned before_cnt;
    before_cnt = expected_bytes.size();
    if (cmd == cfb_pkg::CMD_BEGIN) begin
      frame_open = 1'b0;
      bytes_left = 8'h00;
      body_sum   = 8'h00;
      if (size > MAX_PAYLOAD) begin
        push_frame_byte(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
        header_sum = size[7:0] + id;
        push_frame_byte(cfb_pkg::START_MARK, 1'b0, 1'b0, 1'b0);
        push_frame_byte(id, 1'b0, 1'b0, 1'b0);
        push_frame_byte(size[7:0], 1'b0, 1'b0, 1'b0);
        if (size == 16'd0) begin
          push_frame_byte(header_sum, 1'b0, 1'b0, 1'b0);
          push_frame_byte(8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
          push_frame_byte(header_sum, 1'b0, 1'b0, 1'b1);
          frame_open = 1'b1;
          bytes_left = size[7:0];
        end
      end
    end else if (frame_open) begin
      body_sum   = body_sum + data;
      bytes_left = bytes_left - 8'd1;
      if (bytes_left != 8'd0) begin
        push_frame_byte(data, 1'b0, 1'b0, 1'b1);
      end else begin
        push_frame_byte(data, 1'b0, 1'b0, 1'b0);
        push_frame_byte(body_sum, 1'b1, 1'b0, 1'b1);
        frame_open = 1'b0;
        body_sum   = 8'h00;
      end
    end
    return expected_bytes.size() - before_cnt;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(logic cmd, logic [7:0] id, logic [15:0] size, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    cmd_id_i       <= id;
    payload_size_i <= size;
    payload_byte_i <= data;
    if (predict_frame_bytes(cmd, id, size, data) != 0) framed_items++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_begin(logic [7:0] id, logic [15:0] size);
    send_item(cfb_pkg::CMD_BEGIN, id, size, 8'($urandom));
  endtask

  task automatic send_payload(logic [7:0] data);
    send_item(cfb_pkg::CMD_PAYLOAD, 8'($urandom), 16'($urandom), data);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
          $display("unexpected output: byte %02h frame_end %b too_large %b run_end %b",
                   out_byte_o, frame_end_o, too_large_o, run_end_o);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte_o !== want.out_byte || frame_end_o !== want.frame_end ||
            too_large_o !== want.too_large || run_end_o !== want.run_end) begin
          mismatch_count++;
          if (mismatch_count <= MAX_SHOWN)
            $display("output mismatch: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                     want.out_byte, want.frame_end, want.too_large, want.run_end,
                     out_byte_o, frame_end_o, too_large_o, run_end_o);
        end
      end
    end
  end

  task automatic test_empty_frames();
    send_begin(8'h00, 16'd0);
    send_begin(8'hFF, 16'd0);
  endtask

  task automatic test_oversize_begin();
    send_begin(8'h5A, 16'(MAX_PAYLOAD + 1));
    send_payload(8'h33);
    send_begin(8'($urandom), 16'hFFFF);
  endtask

  task automatic test_short_frames();
    send_begin(8'h01, 16'd1);
    send_payload(8'hFF);
    send_begin(8'hA5, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h80);
  endtask

  task automatic test_abandoned_frame();
    send_begin(8'h07, 16'(MAX_PAYLOAD));
    send_payload(8'h12);
    send_payload(8'h34);
    send_begin(8'h09, 16'd2);
    send_payload(8'hC3);
    send_payload(8'h3C);
  endtask

  task automatic test_stray_payload();
    send_payload(8'h55);
    send_payload(8'hAA);
  endtask

  task automatic test_output_hold();
    recv_idle_pct = 0;
    send_idle_pct = 0;
    hold_request  = 150;
    send_begin(8'($urandom), 16'd12);
    repeat (12) send_payload(8'($urandom));
    send_begin(8'($urandom), 16'd0);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(int unsigned target);
    int unsigned start_cnt;
    int unsigned kind;
    int unsigned size;
    int unsigned sent;
    start_cnt = framed_items;
    while (framed_items - start_cnt < target) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        if ($urandom_range(19) == 0) size = 0;
        else if ($urandom_range(29) == 0) size = $urandom_range(7, 30);
        else size = $urandom_range(1, 6);
        send_begin(8'($urandom), 16'(size));
        sent = size;
        if (size > 1 && $urandom_range(9) == 0) sent = $urandom_range(size - 1);
        repeat (sent) send_payload(8'($urandom));
      end else if (kind < 90) begin
        send_begin(8'($urandom), 16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
        repeat ($urandom_range(2)) send_payload(8'($urandom));
      end else begin
        send_payload(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_idle_pct = 88;
    test_empty_frames();
    test_oversize_begin();
    test_short_frames();
    test_abandoned_frame();
    test_stray_payload();
    test_random_traffic(40);
    wait_for_drain();

    test_output_hold();

    send_idle_pct = 88;
    recv_idle_pct = 21;
    test_random_traffic(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(40);

    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
